FILE: hw/rtl/sbsm_pkg.sv
// shared types and constants of the serial bank switch mapper
package sbsm_pkg;

  localparam int unsigned DIV_STEPS = 5;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS + 1);

  localparam logic [4:0] SHIFT_MARKER = 5'h10;
  localparam logic [4:0] PRG_MAX      = 5'd16;
  localparam logic [5:0] CHR_MAX      = 6'd32;
  localparam logic [4:0] PRG_RESET    = 5'd8;
  localparam logic [5:0] CHR_RESET    = 6'd2;
  localparam logic [3:0] PRG_LAST_RST = 4'd7;

  localparam logic CFG_PRG_COUNT = 1'b0;
  localparam logic CFG_CHR_COUNT = 1'b1;

  typedef enum logic [2:0] {
    TGT_NONE    = 3'd0,
    TGT_PATTERN = 3'd1,
    TGT_PROGRAM = 3'd2,
    TGT_SAVE    = 3'd3,
    TGT_REGLOAD = 3'd4
  } target_t;

  typedef enum logic [1:0] {
    PM_SWITCH32_A = 2'd0,
    PM_SWITCH32_B = 2'd1,
    PM_FIX_FIRST  = 2'd2,
    PM_FIX_LAST   = 2'd3
  } prg_mode_t;

  typedef struct packed {
    logic        op;
    logic [15:0] address;
    logic [7:0]  data_in;
  } in_t;

  typedef struct packed {
    logic [2:0]  target;
    logic [17:0] mapped_address;
    logic        write_enable;
    logic [7:0]  write_data;
    logic [1:0]  mirroring;
  } out_t;

  typedef struct packed {
    logic             accept;
    logic             div_clear;
    logic             div_step;
    logic             div_last;
    logic [CNT_W-1:0] bit_sel;
  } cmd_t;

  typedef struct packed {
    logic recompute;
  } sts_t;

endpackage

FILE: hw/rtl/sbsm_ctrl.sv
// handshake and sequencing controller of the mapper
module sbsm_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  sbsm_pkg::sts_t sts,
  output sbsm_pkg::cmd_t cmd
);
  import sbsm_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_DIVIDE
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] cnt;
  logic             accept;
  logic             last;

  assign in_ready = (state == ST_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;
  assign last     = (cnt == CNT_W'(DIV_STEPS - 1));

  always_comb begin
    cmd.accept    = accept;
    cmd.div_clear = accept && sts.recompute;
    cmd.div_step  = (state == ST_DIVIDE);
    cmd.div_last  = (state == ST_DIVIDE) && last;
    cmd.bit_sel   = CNT_W'(DIV_STEPS - 1) - cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept && sts.recompute) begin
            state <= ST_DIVIDE;
            cnt   <= '0;
          end
        end
        ST_DIVIDE: begin
          if (last) begin
            state <= ST_IDLE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: hw/rtl/sbsm_datapath.sv
// mapper registers, address translation and bit-serial bank remainder units
module sbsm_datapath (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic           cfg_index,
  input  logic [5:0]     cfg_data,
  input  sbsm_pkg::in_t  in_data,
  input  sbsm_pkg::cmd_t cmd,
  output sbsm_pkg::sts_t sts,
  output sbsm_pkg::out_t out_data
);
  import sbsm_pkg::*;

  logic [4:0] prg_count;
  logic [5:0] chr_count;
  logic [4:0] serial_shift;
  logic [4:0] control_bits;
  logic [4:0] pattern_bank_low;
  logic [4:0] pattern_bank_high;
  logic [3:0] program_bank;
  logic [3:0] prg_rem0, prg_rem1;
  logic [4:0] chr_rem0, chr_rem1;
  logic [4:0] part [4];

  logic [4:0] serial_shift_next;
  logic [4:0] control_bits_next;
  logic [4:0] pattern_bank_low_next;
  logic [4:0] pattern_bank_high_next;
  logic [3:0] program_bank_next;
  logic       recompute;
  logic [4:0] shifted;
  logic       is_load;
  out_t       res;

  logic [4:0] prg_n;
  logic [5:0] chr_n;
  logic [4:0] dvd [4];
  logic [5:0] dvs [4];
  logic [4:0] part_next [4];
  logic [5:0] trial [4];

  // clamp bank counts
  always_comb begin
    if (prg_count == '0) begin
      prg_n = 5'd1;
    end else if (prg_count > PRG_MAX) begin
      prg_n = PRG_MAX;
    end else begin
      prg_n = prg_count;
    end
    if (chr_count == '0) begin
      chr_n = 6'd1;
    end else if (chr_count > CHR_MAX) begin
      chr_n = CHR_MAX;
    end else begin
      chr_n = chr_count;
    end
  end

  // serial loader
  always_comb begin
    serial_shift_next      = serial_shift;
    control_bits_next      = control_bits;
    pattern_bank_low_next  = pattern_bank_low;
    pattern_bank_high_next = pattern_bank_high;
    program_bank_next      = program_bank;
    recompute              = 1'b0;
    shifted                = {in_data.data_in[0], serial_shift[4:1]};
    is_load                = in_data.op && in_data.address[15];
    if (is_load) begin
      if (in_data.data_in[7]) begin
        serial_shift_next = SHIFT_MARKER;
        control_bits_next = control_bits | 5'h0C;
        recompute         = 1'b1;
      end else if (serial_shift[0]) begin
        serial_shift_next = SHIFT_MARKER;
        recompute         = 1'b1;
        case (in_data.address[14:13])
          2'd0:    control_bits_next      = shifted;
          2'd1:    pattern_bank_low_next  = shifted;
          2'd2:    pattern_bank_high_next = shifted;
          default: program_bank_next      = shifted[3:0];
        endcase
      end else begin
        serial_shift_next = shifted;
      end
    end
  end

  assign sts.recompute = recompute;

  // translation
  always_comb begin
    res                = '0;
    res.mirroring      = control_bits_next[1:0];
    if (in_data.address[15:13] == 3'd0) begin
      res.target         = TGT_PATTERN;
      res.mapped_address = in_data.address[12] ? {1'b0, chr_rem1, in_data.address[11:0]}
                                               : {1'b0, chr_rem0, in_data.address[11:0]};
      res.write_enable   = in_data.op;
    end else if (in_data.address[15]) begin
      if (in_data.op) begin
        res.target = TGT_REGLOAD;
      end else begin
        res.target         = TGT_PROGRAM;
        res.mapped_address = in_data.address[14] ? {prg_rem1, in_data.address[13:0]}
                                                 : {prg_rem0, in_data.address[13:0]};
      end
    end else if (in_data.address[14:13] == 2'd3) begin
      res.target         = TGT_SAVE;
      res.mapped_address = {5'd0, in_data.address[12:0]};
      res.write_enable   = in_data.op;
    end
    res.write_data = res.write_enable ? in_data.data_in : 8'd0;
  end

  // bank indices to reduce
  always_comb begin
    case (prg_mode_t'(control_bits[3:2]))
      PM_FIX_FIRST: begin
        dvd[0] = 5'd0;
        dvd[1] = {1'b0, program_bank};
      end
      PM_FIX_LAST: begin
        dvd[0] = {1'b0, program_bank};
        dvd[1] = {1'b0, 4'(prg_n - 5'd1)};
      end
      default: begin
        dvd[0] = {1'b0, program_bank[3:1], 1'b0};
        dvd[1] = {1'b0, program_bank[3:1], 1'b1};
      end
    endcase
    if (control_bits[4]) begin
      dvd[2] = pattern_bank_low;
      dvd[3] = pattern_bank_high;
    end else begin
      dvd[2] = {pattern_bank_low[4:1], 1'b0};
      dvd[3] = {pattern_bank_low[4:1], 1'b1};
    end
    dvs[0] = {1'b0, prg_n};
    dvs[1] = {1'b0, prg_n};
    dvs[2] = chr_n;
    dvs[3] = chr_n;
  end

  // restoring remainder, one dividend bit a cycle
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      trial[i] = {part[i], dvd[i][cmd.bit_sel]};
      if (trial[i] >= dvs[i]) begin
        part_next[i] = 5'(trial[i] - dvs[i]);
      end else begin
        part_next[i] = trial[i][4:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prg_count         <= PRG_RESET;
      chr_count         <= CHR_RESET;
      serial_shift      <= SHIFT_MARKER;
      control_bits      <= '0;
      pattern_bank_low  <= '0;
      pattern_bank_high <= '0;
      program_bank      <= '0;
      prg_rem0          <= '0;
      prg_rem1          <= PRG_LAST_RST;
      chr_rem0          <= '0;
      chr_rem1          <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_PRG_COUNT) begin
          prg_count <= cfg_data[4:0];
        end else begin
          chr_count <= cfg_data;
        end
      end
      if (cmd.accept) begin
        serial_shift      <= serial_shift_next;
        control_bits      <= control_bits_next;
        pattern_bank_low  <= pattern_bank_low_next;
        pattern_bank_high <= pattern_bank_high_next;
        program_bank      <= program_bank_next;
      end
      if (cmd.div_last) begin
        prg_rem0 <= part_next[0][3:0];
        prg_rem1 <= part_next[1][3:0];
        chr_rem0 <= part_next[2];
        chr_rem1 <= part_next[3];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      out_data <= res;
    end
    if (cmd.div_clear) begin
      for (int i = 0; i < 4; i++) begin
        part[i] <= '0;
      end
    end else if (cmd.div_step) begin
      for (int i = 0; i < 4; i++) begin
        part[i] <= part_next[i];
      end
    end
  end

endmodule

FILE: hw/rtl/serial_bank_switch_mapper.sv
// top level of the serial bank switch mapper
//
// one bus access (op, address, data_in) is taken per input transfer and one
// translated result (target, mapped_address, write enable and data, mirroring)
// is returned per output transfer, in order.
// the result is registered and valid the cycle after the input transfer.
// plain accesses sustain one transfer per cycle while the output is taken.
// a write that completes a register load or resets the loader recomputes the
// four window offsets: each bank index is reduced modulo its bank count by a
// bit-serial remainder unit, one index bit a cycle, and no new access is taken
// until the remainder units have finished.
// counts are written through cfg_we, cfg_index and cfg_data, only while idle, a rule
// for the user that the block does not enforce; a new count takes effect at the next recompute.
// reset returns counts to 8 program and 2 pattern banks, clears the loader and
// bank registers and fixes program window 1 at the last bank.
// while the receiver stalls the result holds and in_ready stays low.
module serial_bank_switch_mapper (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  sbsm_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output sbsm_pkg::out_t out_data,
  input  logic           cfg_we,
  input  logic           cfg_index,
  input  logic [5:0]     cfg_data
);
  import sbsm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  sbsm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sbsm_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

  a_ready_room : assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (!out_valid || out_ready))
    else $error("input taken while result is held");

  a_loader_reset_busy : assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_data.op && in_data.address[15] && in_data.data_in[7])
      |=> (!in_ready && out_valid && out_data.target == TGT_REGLOAD))
    else $error("loader reset did not start a recompute");

  a_we_target : assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.write_enable)
      |-> (out_data.target == TGT_PATTERN || out_data.target == TGT_SAVE))
    else $error("write enable on a non-writable target");

endmodule
